FILE: rtl/stbs_pkg.sv
// Shared types and constants for the sorted key table with binary-search lookup.
// Used by stbs_front, stbs_back and the top level sorted_table_binary_search.
package stbs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int KEY_W       = 32;
  localparam int OP_W        = 2;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  // One queued transaction from the front end to the search engine.
  typedef struct packed {
    op_t                     op;
    logic signed [KEY_W-1:0] key;
  } item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP
  } bk_state_t;

endpackage

FILE: rtl/stbs_front.sv
// Front end: accepts transactions, drops unused opcodes and queues the rest.
// Depends on stbs_pkg for item_t and the opcode codes.
module stbs_front import stbs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [OP_W-1:0]         in_opcode,
  input  logic signed [KEY_W-1:0] in_key_value,
  output logic                    q_valid,
  output item_t                   q_item,
  input  logic                    q_pop
);

  item_t       fifo_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        accept;
  logic        push;
  logic        known_op;

  assign busy     = (cnt_r == 2'd2);
  assign accept   = start && !busy;
  assign known_op = (in_opcode == OP_CLEAR) || (in_opcode == OP_APPEND) ||
                    (in_opcode == OP_QUERY);
  // Unused opcodes are accepted but never reach the search engine.
  assign push     = accept && known_op;

  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = fifo_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ q_pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= '{op: op_t'(in_opcode), key: in_key_value};
    end
  end

endmodule

FILE: rtl/stbs_back.sv
// Back end: key memory, fill count and the binary-search sequencer.
// Depends on stbs_pkg for item_t, the opcodes and the sequencer states.
module stbs_back import stbs_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  q_valid,
  input  item_t q_item,
  output logic  q_pop,
  output logic  out_valid,
  output logic  out_hit
);

  logic signed [KEY_W-1:0] mem [TABLE_DEPTH];
  logic signed [KEY_W-1:0] rd_data_r;

  bk_state_t               state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [IDX_W-1:0]        low_r, low_nxt;
  logic [IDX_W-1:0]        high_r, high_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic                    last_r, last_nxt;
  logic [IDX_W-1:0]        mid_r, mid_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_hit_r, out_hit_nxt;

  logic                    mem_we;
  logic [IDX_W-1:0]        rd_addr;
  logic [IDX_W:0]          sum;
  logic                    narrow;
  logic                    full;
  logic                    eq;

  assign sum    = {1'b0, low_r} + {1'b0, high_r};
  assign narrow = !(low_r < high_r);
  assign full   = (count_r == CNT_W'(TABLE_DEPTH));
  assign eq     = (rd_data_r == key_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid && q_item.op == OP_QUERY && count_r != '0) begin
          state_nxt = ST_PROBE;
        end
      end
      ST_PROBE: state_nxt = ST_CMP;
      ST_CMP: begin
        if (!(last_r || eq)) begin
          state_nxt = ST_PROBE;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    rd_addr       = mid_r;
    count_nxt     = count_r;
    low_nxt       = low_r;
    high_nxt      = high_r;
    key_nxt       = key_r;
    last_nxt      = last_r;
    mid_nxt       = mid_r;
    out_valid_nxt = 1'b0;
    out_hit_nxt   = out_hit_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_item.op)
            OP_CLEAR: count_nxt = '0;
            OP_APPEND: begin
              if (!full) begin
                mem_we    = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            OP_QUERY: begin
              key_nxt  = q_item.key;
              low_nxt  = '0;
              high_nxt = IDX_W'(count_r - CNT_W'(1));
              // An empty table misses without touching the memory.
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                out_hit_nxt   = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_PROBE: begin
        // Once the window has shrunk to one slot, that slot is the last probe.
        last_nxt = narrow;
        mid_nxt  = narrow ? low_r : sum[IDX_W:1];
        rd_addr  = mid_nxt;
      end
      ST_CMP: begin
        if (last_r || eq) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = eq;
        end else if (key_r > rd_data_r) begin
          low_nxt = mid_r + IDX_W'(1);
        end else begin
          high_nxt = mid_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    low_r     <= low_nxt;
    high_r    <= high_nxt;
    key_r     <= key_nxt;
    last_r    <= last_nxt;
    mid_r     <= mid_nxt;
    out_hit_r <= out_hit_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[IDX_W-1:0]] <= q_item.key;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;

endmodule

FILE: rtl/sorted_table_binary_search.sv
// Top level of the key table with binary-search membership queries.
// Depends on stbs_pkg, stbs_front and stbs_back.
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------
//   input    | start, busy            | in_opcode, in_key_value
//   result   | out_valid (strobe)     | out_hit
//
// A transaction waits in a two-entry queue until the search engine takes it.
// Clear and append stay in the idle state. A query runs a probe and a compare
// state for each of its at most ceil(log2(count)) + 1 probes (11 for a full
// table of 1024 keys): each probe reads the key memory, whose read data is
// registered, then compares. The hit strobe rises in the cycle after the last
// compare. busy rises only while the queue is full. Reset clears the fill count
// and the queue; the key memory keeps its contents. Results cannot be stalled.
module sorted_table_binary_search import stbs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [OP_W-1:0]         in_opcode,
  input  logic signed [KEY_W-1:0] in_key_value,
  output logic                    out_valid,
  output logic                    out_hit
);

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  stbs_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_opcode    (in_opcode),
    .in_key_value (in_key_value),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  stbs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_hit   (out_hit)
  );

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for sorted_table_binary_search: clears, appends and
// membership queries, with the expected hit bits worked out by its own table search.
// Depends on stbs_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_top import stbs_pkg::*;;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int N_ITEMS = 450;
  localparam int INT_MIN = 32'h8000_0000;
  localparam int INT_MAX = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [KEY_W-1:0] key;
    logic [3:0]       gap;
    logic             drain;
  } cmd_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [OP_W-1:0]         in_opcode = OP_CLEAR;
  logic signed [KEY_W-1:0] in_key_value = '0;
  logic                    out_valid;
  logic                    out_hit;

  cmd_t pending_cmds[$];
  logic hit_expected[$];
  cmd_t cur_cmd;
  cmd_t nxt_cmd;
  bit   have_next = 1'b0;
  int   idle_left = 0;
  bit   launch;
  bit   stim_done = 1'b0;
  int   mismatch_count = 0;
  int   n_items = 0;
  int   gap_mode = 1;
  logic exp_hit;

  // Copy of the table as the block should hold it.
  logic signed [KEY_W-1:0] tbl_keys[TABLE_DEPTH];
  int                      tbl_count = 0;

  sorted_table_binary_search i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_opcode    (in_opcode),
    .in_key_value (in_key_value),
    .out_valid    (out_valid),
    .out_hit      (out_hit)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Follows the exact probe order of the block, so unsorted tables give the same
  // answer the hardware search would give.
  function automatic logic lookup_hit(logic signed [KEY_W-1:0] key);
    int lo;
    int hi;
    int mid;
    if (tbl_count == 0) return 1'b0;
    lo = 0;
    hi = tbl_count - 1;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (key == tbl_keys[mid]) return 1'b1;
      if (key > tbl_keys[mid]) lo = mid + 1;
      else hi = mid;
    end
    return key == tbl_keys[lo];
  endfunction

  function automatic int unsigned draw_gap();
    case (gap_mode)
      0: return 0;
      1: return $urandom_range(0, 13);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
    endcase
  endfunction

  task automatic push_cmd(input logic [OP_W-1:0] op, input int key, input bit drain);
    cmd_t c;
    c.opcode = op;
    c.key    = key;
    c.gap    = 4'(draw_gap());
    c.drain  = drain;
    pending_cmds.push_back(c);
    n_items++;
  endtask

  initial begin : gen
    int  keys[$];
    int  n;
    int  m;
    int  pick;
    int  q;
    int  inc_max;
    int  inc_min;
    longint acc;
    longint span;

    // Directed part: empty table, extreme keys, unused opcode, clear semantics.
    push_cmd(OP_QUERY, 0, 1'b0);
    push_cmd(OP_QUERY, INT_MIN, 1'b0);
    push_cmd(OP_CLEAR, -1, 1'b0);
    push_cmd(OP_APPEND, INT_MIN, 1'b0);
    push_cmd(OP_APPEND, -1, 1'b0);
    push_cmd(OP_APPEND, 0, 1'b0);
    push_cmd(OP_APPEND, 1, 1'b0);
    push_cmd(OP_APPEND, INT_MAX, 1'b0);
    push_cmd(OP_QUERY, INT_MIN, 1'b0);
    push_cmd(OP_QUERY, INT_MAX, 1'b0);
    push_cmd(OP_QUERY, 0, 1'b0);
    push_cmd(OP_QUERY, -1, 1'b0);
    push_cmd(OP_QUERY, 1, 1'b0);
    push_cmd(OP_QUERY, 2, 1'b0);
    push_cmd(OP_QUERY, INT_MIN + 1, 1'b0);
    push_cmd(OP_QUERY, INT_MAX - 1, 1'b0);
    push_cmd(OP_UNUSED, 32'h5555_AAAA, 1'b0);
    push_cmd(OP_UNUSED, 32'hAAAA_5555, 1'b0);
    push_cmd(OP_QUERY, -1, 1'b0);
    // The sender holds off here until every pending hit bit has come back.
    push_cmd(OP_CLEAR, 0, 1'b1);
    push_cmd(OP_QUERY, 0, 1'b0);
    push_cmd(OP_QUERY, INT_MAX, 1'b0);
    push_cmd(OP_APPEND, 7, 1'b0);
    push_cmd(OP_QUERY, 7, 1'b0);
    push_cmd(OP_QUERY, 8, 1'b0);

    // Random part: mostly a clear, a fill and a run of queries, with noise mixed in.
    while (n_items < N_ITEMS) begin
      gap_mode = $urandom_range(0, 2);
      push_cmd(OP_CLEAR, $urandom, $urandom_range(0, 3) == 0);
      keys.delete();
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 16);
      if ($urandom_range(0, 3) == 0) begin
        for (int i = 0; i < n; i++) keys.push_back($urandom);
      end else begin
        case ($urandom_range(0, 3))
          0: inc_max = 2;
          1: inc_max = 256;
          2: inc_max = 1 << 20;
          default: inc_max = 32'hFFFF_FFFF / (n + 1);
        endcase
        inc_min = $urandom_range(0, 1);
        span = longint'(n) * inc_max;
        case ($urandom_range(0, 3))
          0: acc = INT_MIN;
          1: acc = longint'(INT_MIN) + 64'hFFFF_FFFF - span;
          default: acc = longint'(INT_MIN) + $urandom_range(0, 32'(32'hFFFF_FFFF - span));
        endcase
        for (int i = 0; i < n; i++) begin
          keys.push_back(int'(acc));
          acc = acc + $urandom_range(inc_min, inc_max);
        end
      end
      foreach (keys[i]) begin
        if ($urandom_range(0, 19) == 0) push_cmd(OP_UNUSED, $urandom, 1'b0);
        push_cmd(OP_APPEND, keys[i], 1'b0);
      end
      m = $urandom_range(1, 10);
      for (int j = 0; j < m; j++) begin
        pick = $urandom_range(0, 19);
        if (keys.size() > 0 && pick < 10) q = keys[$urandom_range(0, keys.size() - 1)];
        else if (keys.size() > 0 && pick < 14)
          q = keys[$urandom_range(0, keys.size() - 1)] + ($urandom_range(0, 1) ? 1 : -1);
        else if (pick == 14) q = $urandom_range(0, 1) ? INT_MIN : INT_MAX;
        else q = $urandom;
        push_cmd(OP_QUERY, q, 1'b0);
        if (pick == 15) begin
          // A late append can break the ordering; the search must still follow it.
          q = $urandom;
          push_cmd(OP_APPEND, q, 1'b0);
          keys.push_back(q);
        end else if (pick == 16) begin
          push_cmd(OP_UNUSED, $urandom, 1'b0);
        end
      end
    end
  end

  // Driver: predicts each transaction as it is accepted, then presents the next.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      launch = 1'b0;
      if (start && !busy) begin
        case (cur_cmd.opcode)
          OP_CLEAR: tbl_count = 0;
          OP_APPEND: begin
            if (tbl_count < TABLE_DEPTH) begin
              tbl_keys[tbl_count] = cur_cmd.key;
              tbl_count++;
            end
          end
          OP_QUERY: hit_expected.push_back(lookup_hit(cur_cmd.key));
          default: ;
        endcase
      end
      if (!start || !busy) begin
        if (!have_next && pending_cmds.size() > 0) begin
          nxt_cmd = pending_cmds.pop_front();
          idle_left = nxt_cmd.gap;
          have_next = 1'b1;
        end
        if (have_next) begin
          if (idle_left > 0) begin
            idle_left--;
          end else if (!nxt_cmd.drain || hit_expected.size() == 0) begin
            cur_cmd = nxt_cmd;
            have_next = 1'b0;
            launch = 1'b1;
          end
        end
        start <= launch;
        if (launch) begin
          in_opcode    <= cur_cmd.opcode;
          in_key_value <= cur_cmd.key;
        end else if (!have_next && pending_cmds.size() == 0) begin
          stim_done = 1'b1;
        end
      end
    end
  end

  // Monitor: results cannot be stalled, so every strobe is checked as it comes.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (hit_expected.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual hit=%0b", $time, out_hit);
        mismatch_count++;
      end else begin
        exp_hit = hit_expected.pop_front();
        if (out_hit !== exp_hit) begin
          $display("%0t: hit mismatch, expected %0b, actual %0b", $time, exp_hit, out_hit);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    while (!(stim_done && hit_expected.size() == 0)) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%0t: timeout", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
